>>> rtl/hfcd_pkg.sv
// Shared types, constants and the CRC-8 fold for the humidity frame decoder.
// Used by hfcd_front, hfcd_fifo, hfcd_back and the top level; no dependencies.
package hfcd_pkg;

	localparam logic [7:0]  CRC_INIT   = 8'hFF;
	localparam logic [7:0]  CRC_POLY   = 8'h31;
	localparam logic [2:0]  FRAME_LAST = 3'd6;
	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic [14:0] TMP_SCALE  = 15'd20000;
	localparam logic [14:0] TMP_OFFSET = 15'd5000;
	localparam int          RAW_W      = 20;
	localparam int          FIFO_DEPTH = 2;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BUSY    = 2'd1,
		ST_CRC_ERR = 2'd2
	} status_t;

	// Completed frame handed from front to back
	typedef struct packed {
		status_t           status;
		logic [RAW_W-1:0]  hum_raw;
		logic [RAW_W-1:0]  tmp_raw;
	} frame_t;

	// One byte through CRC-8, poly 0x31, MSB first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/hfcd_front.sv
// Front end: assembles the 7-byte frame, runs the CRC and classifies the frame.
// Depends on hfcd_pkg; pushes one frame_t per completed frame into the queue.
module hfcd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         rx_byte,
	input  logic               frame_start,
	output logic               push_valid,
	input  logic               push_ready,
	output hfcd_pkg::frame_t   push_frame
);

	logic [2:0]  idx_q;
	logic [7:0]  crc_q;
	logic        busy_q;
	logic [39:0] payload_q;

	logic [2:0]  eff_idx;
	logic [7:0]  crc_base;
	logic        is_last;
	logic        take;

	// start mark always restarts at byte 0
	assign eff_idx  = frame_start ? 3'd0 : idx_q;
	assign is_last  = (eff_idx == hfcd_pkg::FRAME_LAST);
	assign crc_base = (eff_idx == 3'd0) ? hfcd_pkg::CRC_INIT : crc_q;
	assign byte_ready = push_ready;
	assign take     = byte_valid && byte_ready;

	// classification of the finished frame; busy wins over CRC
	always_comb begin
		push_valid         = take && is_last;
		push_frame.hum_raw = payload_q[39:20];
		push_frame.tmp_raw = payload_q[19:0];
		if (busy_q) begin
			push_frame.status = hfcd_pkg::ST_BUSY;
		end else if (crc_q != rx_byte) begin
			push_frame.status = hfcd_pkg::ST_CRC_ERR;
		end else begin
			push_frame.status = hfcd_pkg::ST_OK;
		end
	end

	// frame assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= 3'd0;
			crc_q  <= hfcd_pkg::CRC_INIT;
			busy_q <= 1'b0;
		end else if (take) begin
			if (is_last) begin
				idx_q <= 3'd0;
				crc_q <= hfcd_pkg::CRC_INIT;
			end else begin
				idx_q <= eff_idx + 3'd1;
				crc_q <= hfcd_pkg::crc_fold(crc_base, rx_byte);
				if (eff_idx == 3'd0) begin
					busy_q <= rx_byte[7];
				end
			end
		end
	end

	// data bytes 1..5, byte 5 lowest
	always_ff @(posedge clk) begin
		if (take && !is_last && (eff_idx != 3'd0)) begin
			payload_q <= {payload_q[31:0], rx_byte};
		end
	end

endmodule

>>> rtl/hfcd_fifo.sv
// Short queue of completed frames between front and back ends.
// Depends on hfcd_pkg (frame_t, FIFO_DEPTH).
module hfcd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  hfcd_pkg::frame_t   push_frame,
	output logic               pop_valid,
	input  logic               pop_ready,
	output hfcd_pkg::frame_t   pop_frame
);

	localparam int PTR_W = $clog2(hfcd_pkg::FIFO_DEPTH);
	localparam int CNT_W = $clog2(hfcd_pkg::FIFO_DEPTH + 1);

	hfcd_pkg::frame_t   mem_q [hfcd_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(hfcd_pkg::FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_frame  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

endmodule

>>> rtl/hfcd_back.sv
// Back end: scales raw values to hundredths and holds the result register.
// Depends on hfcd_pkg; two stages (products, then output register).
module hfcd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	output logic               frame_ready,
	input  hfcd_pkg::frame_t   frame,
	output logic               res_valid,
	input  logic               res_ready,
	output logic [1:0]         status_code,
	output logic [19:0]        rh_count,
	output logic [19:0]        t_count,
	output logic [13:0]        humidity_centi,
	output logic [14:0]        temperature_centi
);

	logic               valid_s1;
	hfcd_pkg::frame_t   frame_s1;
	logic [33:0]        hum_prod_s1;
	logic [34:0]        tmp_prod_s1;

	logic               valid_s2;
	logic [1:0]         status_s2;
	logic [19:0]        hum_s2;
	logic [19:0]        tmp_s2;
	logic [13:0]        hc_s2;
	logic [14:0]        tc_s2;

	logic               adv_s2;
	logic               adv_s1;
	logic               ok_s1;
	logic [14:0]        tc_full;

	assign adv_s2      = !valid_s2 || res_ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign frame_ready = adv_s1;
	assign ok_s1       = (frame_s1.status == hfcd_pkg::ST_OK);
	assign tc_full     = tmp_prod_s1[34:20] - hfcd_pkg::TMP_OFFSET;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= frame_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// stage 1: the two scale products
	always_ff @(posedge clk) begin
		if (adv_s1 && frame_valid) begin
			frame_s1    <= frame;
			hum_prod_s1 <= 34'(frame.hum_raw) * 34'(hfcd_pkg::HUM_SCALE);
			tmp_prod_s1 <= 35'(frame.tmp_raw) * 35'(hfcd_pkg::TMP_SCALE);
		end
	end

	// stage 2: shift, offset, zero fields unless status is OK
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			status_s2 <= frame_s1.status;
			hum_s2    <= ok_s1 ? frame_s1.hum_raw : '0;
			tmp_s2    <= ok_s1 ? frame_s1.tmp_raw : '0;
			hc_s2     <= ok_s1 ? hum_prod_s1[33:20] : '0;
			tc_s2     <= ok_s1 ? tc_full : '0;
		end
	end

	assign res_valid         = valid_s2;
	assign status_code       = status_s2;
	assign rh_count          = hum_s2;
	assign t_count           = tmp_s2;
	assign humidity_centi    = hc_s2;
	assign temperature_centi = tc_s2;

endmodule

>>> rtl/humidity_frame_crc_decoder_top.sv
// Humidity/temperature frame decoder, top level.
// Depends on hfcd_pkg, hfcd_front, hfcd_fifo and hfcd_back.
//
// Takes the 7-byte sensor response one byte per transaction (tuser marks the
// first byte) and gives one result transaction per completed frame. A byte is
// accepted every cycle while the frame queue has room; the CRC-8 of each byte
// is folded within that cycle. The frame enters the queue on the edge that
// accepts its CRC byte; its result then passes the product stage and the
// output register. The front keeps taking bytes while results wait on the
// output side; with the output held off, four frames (two in the back stages,
// two in the queue) are absorbed before the input stalls.
module humidity_frame_crc_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tuser,   // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata    // [1:0] status_code, [21:2] rh_count,
	                                    // [41:22] t_count,
	                                    // [55:42] humidity_centi,
	                                    // [70:56] temperature_centi, [71] zero
);

	logic               push_valid;
	logic               push_ready;
	hfcd_pkg::frame_t   push_frame;
	logic               pop_valid;
	logic               pop_ready;
	hfcd_pkg::frame_t   pop_frame;
	logic [1:0]         status_code;
	logic [19:0]        rh_count;
	logic [19:0]        t_count;
	logic [13:0]        humidity_centi;
	logic [14:0]        temperature_centi;

	hfcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (s_axis_tvalid),
		.byte_ready  (s_axis_tready),
		.rx_byte     (s_axis_tdata),
		.frame_start (s_axis_tuser),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_frame  (push_frame)
	);

	hfcd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_frame (push_frame),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_frame  (pop_frame)
	);

	hfcd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.frame_valid       (pop_valid),
		.frame_ready       (pop_ready),
		.frame             (pop_frame),
		.res_valid         (m_axis_tvalid),
		.res_ready         (m_axis_tready),
		.status_code       (status_code),
		.rh_count          (rh_count),
		.t_count           (t_count),
		.humidity_centi    (humidity_centi),
		.temperature_centi (temperature_centi)
	);

	// result packing, first field lowest
	assign m_axis_tdata = {1'b0, temperature_centi, humidity_centi, t_count,
		rh_count, status_code};

endmodule
